/* rtl/local_interrupt_controller_timer_macros.svh */
// assertion macros shared by the rtl files
// each check is clocked on clk and held off while rst_n is low
`ifndef LOCAL_INTERRUPT_CONTROLLER_TIMER_MACROS_SVH
`define LOCAL_INTERRUPT_CONTROLLER_TIMER_MACROS_SVH

`ifndef SYNTH
`define LICT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LICT_CHK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define LICT_CHK(label, prop, msg)
`define LICT_CHK_NEXT(label, cond, prop, msg)
`endif

`endif

/* rtl/lict_pkg.sv */
`default_nettype none
package lict_pkg;

  // default count width
  localparam int COUNT_BITS_DEF = 32;
  localparam int PRESCALE_BITS  = 7;

  // request kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_ACK   = 2'd3
  } kind_t;

  // register byte offsets
  localparam logic [9:0] OFS_ID       = 10'h020;
  localparam logic [9:0] OFS_EOI      = 10'h0B0;
  localparam logic [9:0] OFS_SPUR     = 10'h0F0;
  localparam logic [9:0] OFS_CMD_LO   = 10'h300;
  localparam logic [9:0] OFS_CMD_HI   = 10'h310;
  localparam logic [9:0] OFS_TMR_LVT  = 10'h320;
  localparam logic [9:0] OFS_LINT0    = 10'h350;
  localparam logic [9:0] OFS_INIT_CNT = 10'h380;
  localparam logic [9:0] OFS_CUR_CNT  = 10'h390;
  localparam logic [9:0] OFS_DIVIDE   = 10'h3E0;

  // bit positions
  localparam int LVT_MASK_BIT = 16;
  localparam int PENDING_BIT  = 12;
  localparam int SW_EN_BIT    = 8;

  // reset values
  localparam logic [31:0] LVT_RESET  = 32'h0001_0000;
  localparam logic [8:0]  SPUR_RESET = 9'h0FF;

  // one result, read_data in the lowest bits
  typedef struct packed {
    logic        eoi_pulse;
    logic        ipi_trigger;
    logic        ipi_level;
    logic [2:0]  ipi_mode;
    logic [7:0]  ipi_vector;
    logic [7:0]  ipi_dest;
    logic        ipi_send;
    logic [7:0]  timer_vector;
    logic        timer_irq;
    logic [31:0] read_data;
  } result_t;

  // timer controls for the current request
  typedef struct packed {
    logic tick;
    logic load;
  } tmr_ctrl_t;

  // divide setting to tick divisor: {3,1,0} 000..110 -> 2..128, 111 -> 1
  function automatic logic [7:0] divisor(input logic [3:0] cfg);
    logic [2:0] sel;
    sel = {cfg[3], cfg[1:0]};
    return (sel == 3'b111) ? 8'd1 : (8'd2 << sel);
  endfunction

endpackage
`default_nettype wire

/* rtl/lict_timer.sv */
`default_nettype none
`include "local_interrupt_controller_timer_macros.svh"
module lict_timer #(
  parameter int COUNT_BITS = lict_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lict_pkg::tmr_ctrl_t   ctrl,
  input  wire logic [COUNT_BITS-1:0] load_val,
  input  wire logic [3:0]            divide_cfg,
  output logic      [COUNT_BITS-1:0] count,
  output logic                       expire
);
  import lict_pkg::*;

  logic [PRESCALE_BITS-1:0] pre_r, pre_nxt, pre_inc;
  logic [COUNT_BITS-1:0]    count_r, count_nxt, count_dec;
  logic                     roll;

  // prescaler and countdown
  always_comb begin
    pre_inc   = pre_r + 1'b1;
    count_dec = count_r - {{(COUNT_BITS-1){1'b0}}, 1'b1};
    roll      = ({1'b0, pre_inc} >= divisor(divide_cfg)) || (pre_inc == '0);
    pre_nxt   = pre_r;
    count_nxt = count_r;
    expire    = 1'b0;
    if (ctrl.load) begin
      count_nxt = load_val;
      pre_nxt   = '0;
    end else if (ctrl.tick && (count_r != '0)) begin
      if (roll) begin
        pre_nxt   = '0;
        count_nxt = count_dec;
        expire    = (count_dec == '0);
      end else begin
        pre_nxt = pre_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r   <= '0;
      count_r <= '0;
    end else begin
      pre_r   <= pre_nxt;
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

  `LICT_CHK_NEXT(a_expire_zero, expire, count_r == '0, "expiry left a nonzero count")
  `LICT_CHK_NEXT(a_stopped_holds, (!ctrl.load && count_r == '0), count_r == '0, "stopped timer moved without a load")

endmodule
`default_nettype wire

/* rtl/lict_regs.sv */
`default_nettype none
`include "local_interrupt_controller_timer_macros.svh"
module lict_regs #(
  parameter int COUNT_BITS = lict_pkg::COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire lict_pkg::kind_t   kind,
  input  wire logic [9:0]        reg_offset,
  input  wire logic [31:0]       write_data,
  input  wire logic [7:0]        identity,
  output lict_pkg::result_t      res
);
  import lict_pkg::*;

  logic [8:0]            spur_r, spur_nxt;
  logic [31:0]           lint0_r, lint0_nxt;
  logic [31:0]           tlvt_r, tlvt_nxt;
  logic [7:0]            cmd_hi_r, cmd_hi_nxt;
  logic [15:0]           cmd_lo_r, cmd_lo_nxt;
  logic                  pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] init_r, init_nxt;
  logic [3:0]            div_r, div_nxt;
  logic [COUNT_BITS-1:0] cur_count;
  logic                  expire;
  logic                  is_wr;
  tmr_ctrl_t             tctrl;

  assign is_wr = go && (kind == KIND_WRITE);

  // timer controls
  always_comb begin
    tctrl.tick = go && (kind == KIND_TICK);
    tctrl.load = is_wr && (reg_offset == OFS_INIT_CNT);
  end

  lict_timer #(.COUNT_BITS(COUNT_BITS)) u_timer (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (tctrl),
    .load_val   (write_data[COUNT_BITS-1:0]),
    .divide_cfg (div_r),
    .count      (cur_count),
    .expire     (expire)
  );

  // register writes and result
  always_comb begin
    spur_nxt   = spur_r;
    lint0_nxt  = lint0_r;
    tlvt_nxt   = tlvt_r;
    cmd_hi_nxt = cmd_hi_r;
    cmd_lo_nxt = cmd_lo_r;
    pend_nxt   = pend_r;
    init_nxt   = init_r;
    div_nxt    = div_r;
    res        = '0;

    if (go && (kind == KIND_ACK)) begin
      pend_nxt = 1'b0;
    end

    if (go && (kind == KIND_READ)) begin
      unique case (reg_offset)
        OFS_ID:       res.read_data = {identity, 24'd0};
        OFS_SPUR:     res.read_data = 32'(spur_r);
        OFS_LINT0:    res.read_data = lint0_r;
        OFS_CMD_LO:   res.read_data = 32'({cmd_lo_r[15:13], pend_r, cmd_lo_r[11:0]});
        OFS_CMD_HI:   res.read_data = {cmd_hi_r, 24'd0};
        OFS_TMR_LVT:  res.read_data = tlvt_r;
        OFS_INIT_CNT: res.read_data = 32'(init_r);
        OFS_CUR_CNT:  res.read_data = 32'(cur_count);
        OFS_DIVIDE:   res.read_data = 32'(div_r);
        default:      res.read_data = '0;
      endcase
    end

    if (is_wr) begin
      unique case (reg_offset)
        OFS_EOI:      res.eoi_pulse = 1'b1;
        OFS_SPUR:     spur_nxt = write_data[8:0];
        OFS_LINT0:    lint0_nxt = write_data;
        OFS_CMD_HI:   cmd_hi_nxt = write_data[31:24];
        OFS_CMD_LO: begin
          cmd_lo_nxt       = {write_data[15:13], 1'b0, write_data[11:0]};
          pend_nxt         = 1'b1;
          res.ipi_send     = 1'b1;
          res.ipi_dest     = cmd_hi_r;
          res.ipi_vector   = write_data[7:0];
          res.ipi_mode     = write_data[10:8];
          res.ipi_level    = write_data[14];
          res.ipi_trigger  = write_data[15];
        end
        OFS_TMR_LVT:  tlvt_nxt = write_data;
        OFS_INIT_CNT: init_nxt = write_data[COUNT_BITS-1:0];
        OFS_DIVIDE:   div_nxt = {write_data[3], 1'b0, write_data[1:0]};
        default:      ;
      endcase
    end

    // timer delivery
    if (expire && !tlvt_r[LVT_MASK_BIT] && spur_r[SW_EN_BIT]) begin
      res.timer_irq    = 1'b1;
      res.timer_vector = tlvt_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spur_r   <= SPUR_RESET;
      lint0_r  <= LVT_RESET;
      tlvt_r   <= LVT_RESET;
      cmd_hi_r <= '0;
      cmd_lo_r <= '0;
      pend_r   <= 1'b0;
      init_r   <= '0;
      div_r    <= '0;
    end else begin
      spur_r   <= spur_nxt;
      lint0_r  <= lint0_nxt;
      tlvt_r   <= tlvt_nxt;
      cmd_hi_r <= cmd_hi_nxt;
      cmd_lo_r <= cmd_lo_nxt;
      pend_r   <= pend_nxt;
      init_r   <= init_nxt;
      div_r    <= div_nxt;
    end
  end

  `LICT_CHK_NEXT(a_ack_clears, (go && kind == KIND_ACK), !pend_r, "ack left pending set")
  `LICT_CHK_NEXT(a_launch_sets, res.ipi_send, pend_r, "launch did not set pending")

endmodule
`default_nettype wire

/* rtl/local_interrupt_controller_timer.sv */
`default_nettype none
// Local interrupt controller with a one-shot timer and IPI launch on an xAPIC-style register
// map. Every request (bus read, bus write, timer tick or IPI acknowledge, chosen by in_tuser)
// gives exactly one result. The block takes one request per clock while out_tready stays high:
// a request is registered in the input stage, where the register file and timer update in a
// single pass, and its result is then shown from the output register. While a result waits
// in the output register the input stage takes at most one more request and then holds
// in_tready low until the result is taken. cfg_data sets the identity returned in ID bits
// 31:24; write it only while the block is idle.
`include "local_interrupt_controller_timer_macros.svh"
module local_interrupt_controller_timer #(
  parameter int COUNT_BITS = lict_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,     // apic_identity
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,     // reg_offset[9:0], write_data[41:10], zero pad
  input  wire logic [1:0]  in_tuser,     // kind[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata     // read_data[31:0], timer_irq[32], timer_vector[40:33],
                                         // ipi_send[41], ipi_dest[49:42], ipi_vector[57:50],
                                         // ipi_mode[60:58], ipi_level[61], ipi_trigger[62],
                                         // eoi_pulse[63]
);
  import lict_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  kind_t       kind_r;
  logic [9:0]  ofs_r;
  logic [31:0] wd_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res;
  logic [7:0]  ident_r;
  logic        adv, go, in_acc;

  // identity register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
    end else if (cfg_valid) begin
      ident_r <= cfg_data;
    end
  end

  // stage control
  assign adv       = !out_valid_r || out_tready;
  assign go        = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_acc ? 1'b1 : (go ? 1'b0 : in_valid_r);
    out_valid_nxt = go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= kind_t'(in_tuser);
      ofs_r  <= in_tdata[9:0];
      wd_r   <= in_tdata[41:10];
    end
  end

  lict_regs #(.COUNT_BITS(COUNT_BITS)) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .kind       (kind_r),
    .reg_offset (ofs_r),
    .write_data (wd_r),
    .identity   (ident_r),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  `LICT_CHK_NEXT(a_stage_holds, (in_valid_r && !adv), in_valid_r, "input stage dropped a request")
  `LICT_CHK(a_irq_ipi_excl, !(out_valid_r && res_r.timer_irq && res_r.ipi_send), "timer irq and ipi launch in one result")

endmodule
`default_nettype wire

/* verif/lict_result_checker.sv */
`timescale 1ns / 100ps
// watches the request, result and identity channels, predicts each result and compares
module lict_result_checker #(
  parameter int COUNT_BITS = lict_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,     // reg_offset[9:0], write_data[41:10], zero pad
  input  logic [1:0]  in_tuser,     // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,    // result_t, read_data in the lowest bits
  output int          fail_count,
  output int          results_due
);
  import lict_pkg::*;

  localparam logic [31:0] COUNT_MASK = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

  // predicted register file and timer
  logic [7:0]  identity_r;
  logic [8:0]  spur_r;
  logic [31:0] lint0_r;
  logic [31:0] tmr_lvt_r;
  logic [7:0]  cmd_hi_r;
  logic [15:0] cmd_lo_r;
  logic        pending_r;
  logic [31:0] init_cnt_r;
  logic [31:0] cur_cnt_r;
  logic [3:0]  div_r;
  logic [6:0]  presc_r;

  result_t expected_results [$];
  int      fault_total = 0;

  // ticks per count step for a divide setting
  function automatic logic [7:0] tick_period(input logic [3:0] div_cfg);
    case ({div_cfg[3], div_cfg[1:0]})
      3'b000:  return 8'd2;
      3'b001:  return 8'd4;
      3'b010:  return 8'd8;
      3'b011:  return 8'd16;
      3'b100:  return 8'd32;
      3'b101:  return 8'd64;
      3'b110:  return 8'd128;
      default: return 8'd1;
    endcase
  endfunction

  // advance the predicted state by one request and give its result
  function automatic result_t predict_request(input kind_t kind, input logic [9:0] ofs,
                                              input logic [31:0] wd);
    result_t r;
    r = '0;
    case (kind)
      KIND_READ: begin
        case (ofs)
          OFS_ID:       r.read_data = {identity_r, 24'h0};
          OFS_SPUR:     r.read_data = {23'h0, spur_r};
          OFS_LINT0:    r.read_data = lint0_r;
          OFS_CMD_LO:   r.read_data = {16'h0, cmd_lo_r} | (32'(pending_r) << PENDING_BIT);
          OFS_CMD_HI:   r.read_data = {cmd_hi_r, 24'h0};
          OFS_TMR_LVT:  r.read_data = tmr_lvt_r;
          OFS_INIT_CNT: r.read_data = init_cnt_r;
          OFS_CUR_CNT:  r.read_data = cur_cnt_r;
          OFS_DIVIDE:   r.read_data = {28'h0, div_r};
          default:      r.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (ofs)
          OFS_EOI:     r.eoi_pulse = 1'b1;
          OFS_SPUR:    spur_r = wd[8:0];
          OFS_LINT0:   lint0_r = wd;
          OFS_CMD_HI:  cmd_hi_r = wd[31:24];
          OFS_CMD_LO: begin
            cmd_lo_r = wd[15:0];
            cmd_lo_r[PENDING_BIT] = 1'b0;
            pending_r = 1'b1;
            r.ipi_send    = 1'b1;
            r.ipi_dest    = cmd_hi_r;
            r.ipi_vector  = wd[7:0];
            r.ipi_mode    = wd[10:8];
            r.ipi_level   = wd[14];
            r.ipi_trigger = wd[15];
          end
          OFS_TMR_LVT: tmr_lvt_r = wd;
          OFS_INIT_CNT: begin
            init_cnt_r = wd & COUNT_MASK;
            cur_cnt_r  = init_cnt_r;
            presc_r    = '0;
          end
          OFS_DIVIDE:  div_r = {wd[3], 1'b0, wd[1:0]};
          default: ;
        endcase
      end
      KIND_TICK: begin
        // a stopped timer ignores ticks
        if (cur_cnt_r != '0) begin
          presc_r = presc_r + 7'd1;
          if ({1'b0, presc_r} >= tick_period(div_r) || presc_r == '0) begin
            presc_r   = '0;
            cur_cnt_r = (cur_cnt_r - 32'd1) & COUNT_MASK;
            if (cur_cnt_r == '0 && !tmr_lvt_r[LVT_MASK_BIT] && spur_r[SW_EN_BIT]) begin
              r.timer_irq    = 1'b1;
              r.timer_vector = tmr_lvt_r[7:0];
            end
          end
        end
      end
      default: pending_r = 1'b0;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fault_total++;
    end
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst_n) begin
      identity_r = '0;
      spur_r     = SPUR_RESET;
      lint0_r    = LVT_RESET;
      tmr_lvt_r  = LVT_RESET;
      cmd_hi_r   = '0;
      cmd_lo_r   = '0;
      pending_r  = 1'b0;
      init_cnt_r = '0;
      cur_cnt_r  = '0;
      div_r      = '0;
      presc_r    = '0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) identity_r = cfg_data;
      // results leave before the new request is predicted
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $error("result 0x%0h arrived with no request outstanding", out_tdata);
          fault_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("timer_irq", 32'(want.timer_irq), 32'(got.timer_irq));
          compare_field("timer_vector", 32'(want.timer_vector), 32'(got.timer_vector));
          compare_field("ipi_send", 32'(want.ipi_send), 32'(got.ipi_send));
          compare_field("ipi_dest", 32'(want.ipi_dest), 32'(got.ipi_dest));
          compare_field("ipi_vector", 32'(want.ipi_vector), 32'(got.ipi_vector));
          compare_field("ipi_mode", 32'(want.ipi_mode), 32'(got.ipi_mode));
          compare_field("ipi_level", 32'(want.ipi_level), 32'(got.ipi_level));
          compare_field("ipi_trigger", 32'(want.ipi_trigger), 32'(got.ipi_trigger));
          compare_field("eoi_pulse", 32'(want.eoi_pulse), 32'(got.eoi_pulse));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_request(kind_t'(in_tuser), in_tdata[9:0],
                                                   in_tdata[41:10]));
    end
    fail_count  <= fault_total;
    results_due <= expected_results.size();
  end

endmodule

/* verif/tb_local_interrupt_controller_timer.sv */
`timescale 1ns / 100ps
module tb_local_interrupt_controller_timer;
  import lict_pkg::*;

  localparam int COUNT_BITS  = COUNT_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 370;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tready = 1'b0;
  wire         cfg_ready;
  wire         in_tready;
  wire         out_tvalid;
  wire  [63:0] out_tdata;

  int   fail_count;
  int   results_due;
  int   requests_sent = 0;
  int   quiet_cycles = 0;
  logic steady_stream = 1'b0;

  local_interrupt_controller_timer #(.COUNT_BITS(COUNT_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lict_result_checker #(.COUNT_BITS(COUNT_BITS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // receiver stalls at random unless the stream is held steady
  always @(posedge clk) begin
    out_tready <= steady_stream || ($urandom_range(99) >= 34);
  end

  // stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[local_interrupt_controller_timer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic push_request(input kind_t kind, input logic [9:0] ofs,
                              input logic [31:0] wd);
    while (!steady_stream && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'h0, wd, ofs};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // hold the sender until every result is back
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_identity(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [9:0] pick_register();
    case ($urandom_range(9))
      0:       return OFS_ID;
      1:       return OFS_EOI;
      2:       return OFS_SPUR;
      3:       return OFS_CMD_LO;
      4:       return OFS_CMD_HI;
      5:       return OFS_TMR_LVT;
      6:       return OFS_LINT0;
      7:       return OFS_INIT_CNT;
      8:       return OFS_CUR_CNT;
      default: return OFS_DIVIDE;
    endcase
  endfunction

  task automatic run_directed();
    // identity, reset values, read-only and write-only registers
    push_request(KIND_READ, OFS_ID, '0);
    push_request(KIND_WRITE, OFS_ID, 32'hFFFF_FFFF);
    push_request(KIND_READ, OFS_SPUR, '0);
    push_request(KIND_READ, OFS_TMR_LVT, '0);
    push_request(KIND_READ, OFS_EOI, 32'hFFFF_FFFF);
    push_request(KIND_WRITE, OFS_EOI, 32'hFFFF_FFFF);
    // misaligned and unknown offsets
    push_request(KIND_READ, 10'h022, '0);
    push_request(KIND_WRITE, 10'h3FF, 32'hFFFF_FFFF);
    // implemented bits only
    push_request(KIND_WRITE, OFS_SPUR, 32'hFFFF_FFFF);
    push_request(KIND_READ, OFS_SPUR, '0);
    push_request(KIND_WRITE, OFS_DIVIDE, 32'hFFFF_FFFF);
    push_request(KIND_READ, OFS_DIVIDE, '0);
    // launch, launch while pending, then acknowledge twice
    push_request(KIND_WRITE, OFS_CMD_HI, 32'hFFFF_FFFF);
    push_request(KIND_WRITE, OFS_CMD_LO, 32'hFFFF_FFFF);
    push_request(KIND_WRITE, OFS_CMD_LO, '0);
    push_request(KIND_READ, OFS_CMD_LO, '0);
    push_request(KIND_ACK, 10'h3FF, 32'hFFFF_FFFF);
    push_request(KIND_ACK, '0, '0);
    push_request(KIND_WRITE, OFS_CUR_CNT, 32'hFFFF_FFFF);
    // short countdown at divide by one, then a tick on the stopped timer
    push_request(KIND_WRITE, OFS_TMR_LVT, 32'h0000_00FE);
    push_request(KIND_WRITE, OFS_INIT_CNT, 32'd2);
    push_request(KIND_TICK, '0, '0);
    push_request(KIND_TICK, 10'h3FF, 32'hFFFF_FFFF);
    push_request(KIND_TICK, '0, '0);
    push_request(KIND_WRITE, OFS_LINT0, 32'hFFFF_FFFF);
    push_request(KIND_READ, OFS_LINT0, '0);
    // largest count, then stop it
    push_request(KIND_WRITE, OFS_INIT_CNT, 32'hFFFF_FFFF);
    push_request(KIND_READ, OFS_CUR_CNT, '0);
    push_request(KIND_WRITE, OFS_INIT_CNT, '0);
  endtask

  // set up the timer and tick it at least until it expires
  task automatic run_countdown();
    logic [31:0] dv;
    logic [31:0] lvt;
    logic [2:0]  sel;
    int          cnt;
    int          per;
    int          n;
    int          ticks;
    int          r;
    dv = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: {dv[3], dv[1:0]} = 3'b111;
      4, 5, 6:    {dv[3], dv[1:0]} = 3'b000;
      7, 8:       {dv[3], dv[1:0]} = 3'b001;
      default: ;
    endcase
    push_request(KIND_WRITE, OFS_DIVIDE, dv);
    lvt = $urandom;
    if ($urandom_range(9) < 7) lvt[LVT_MASK_BIT] = 1'b0;
    push_request(KIND_WRITE, OFS_TMR_LVT, lvt);
    if ($urandom_range(9) < 8)
      push_request(KIND_WRITE, OFS_SPUR, $urandom | (32'd1 << SW_EN_BIT));
    cnt = $urandom_range(1, 8);
    push_request(KIND_WRITE, OFS_INIT_CNT, 32'(cnt));
    sel = {dv[3], dv[1:0]};
    per = (sel == 3'b111) ? 1 : (2 << sel);
    n = cnt * per + $urandom_range(0, 3);
    ticks = 0;
    while (ticks < n) begin
      r = $urandom_range(99);
      if (r < 12) begin
        push_request(KIND_READ, OFS_CUR_CNT, $urandom);
      end else if (r < 15) begin
        push_request(KIND_ACK, 10'($urandom), $urandom);
      end else begin
        push_request(KIND_TICK, 10'($urandom), $urandom);
        ticks++;
      end
    end
  endtask

  // command register sequence with random content
  task automatic run_ipi();
    push_request(KIND_WRITE, OFS_CMD_HI, $urandom);
    if ($urandom_range(1) == 0) push_request(KIND_READ, OFS_CMD_HI, $urandom);
    push_request(KIND_WRITE, OFS_CMD_LO, $urandom);
    push_request(KIND_READ, OFS_CMD_LO, $urandom);
    if ($urandom_range(9) < 7) push_request(KIND_ACK, 10'($urandom), $urandom);
    push_request(KIND_READ, OFS_CMD_LO, $urandom);
  endtask

  // single request, mostly to known registers
  task automatic random_request();
    int          r;
    logic [9:0]  ofs;
    logic [31:0] wd;
    r   = $urandom_range(99);
    ofs = pick_register();
    wd  = $urandom;
    if (r < 35) begin
      push_request(KIND_TICK, 10'($urandom), $urandom);
    end else if (r < 55) begin
      push_request(KIND_READ, ofs, wd);
    end else if (r < 60) begin
      push_request(KIND_READ, 10'($urandom), wd);
    end else if (r < 88) begin
      if (ofs == OFS_INIT_CNT && $urandom_range(9) != 0) wd = $urandom_range(0, 40);
      push_request(KIND_WRITE, ofs, wd);
    end else if (r < 92) begin
      push_request(KIND_WRITE, 10'($urandom), wd);
    end else begin
      push_request(KIND_ACK, 10'($urandom), $urandom);
    end
  endtask

  task automatic random_traffic(input int n_items);
    int first;
    int r;
    first = requests_sent;
    while (requests_sent - first < n_items) begin
      r = $urandom_range(99);
      if (r < 20) run_countdown();
      else if (r < 30) run_ipi();
      else random_request();
    end
  endtask

  // reset, then phases with a fresh identity each
  initial begin
    logic [7:0] ident;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < 5; p++) begin
      wait_for_drain();
      case (p)
        0:       ident = 8'hFF;
        1:       ident = 8'h00;
        default: ident = $urandom;
      endcase
      write_identity(ident);
      steady_stream <= (p == 2);
      if (p == 0) run_directed();
      random_traffic(PHASE_ITEMS);
    end
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("[local_interrupt_controller_timer] OK");
    end else begin
      $display("[local_interrupt_controller_timer] ERROR");
    end
    $finish;
  end

endmodule
